### sv/majority_clocked_lfsr_word_gen_core_assert.svh
// Assertion macros for the majority-clocked word generator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MAJORITY_CLOCKED_LFSR_WORD_GEN_CORE_ASSERT_SVH
`define MAJORITY_CLOCKED_LFSR_WORD_GEN_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define MCLWG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause
`define MCLWG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/mclwg_pkg.sv
`default_nettype none

package mclwg_pkg;

    // register and field widths
    localparam int unsigned A_W   = 19;
    localparam int unsigned B_W   = 22;
    localparam int unsigned C_W   = 23;
    localparam int unsigned OUT_W = 23;

    // majority clock bits
    localparam int unsigned A_CLK_BIT = 8;
    localparam int unsigned B_CLK_BIT = 10;
    localparam int unsigned C_CLK_BIT = 10;

    // feedback taps (top bit of each register is also its output)
    localparam int unsigned A_TAP0 = 18;
    localparam int unsigned A_TAP1 = 17;
    localparam int unsigned A_TAP2 = 16;
    localparam int unsigned A_TAP3 = 13;
    localparam int unsigned B_TAP0 = 21;
    localparam int unsigned B_TAP1 = 20;
    localparam int unsigned C_TAP0 = 22;
    localparam int unsigned C_TAP1 = 21;
    localparam int unsigned C_TAP2 = 20;
    localparam int unsigned C_TAP3 = 7;

    typedef logic [A_W-1:0]   t_reg_a;
    typedef logic [B_W-1:0]   t_reg_b;
    typedef logic [C_W-1:0]   t_reg_c;
    typedef logic [OUT_W-1:0] t_out_word;

    // item kinds
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_GEN  = 1'b1
    } t_kind;

endpackage

`default_nettype wire

### sv/mclwg_if.sv
`default_nettype none

// Input channel: one load or generate beat
interface mclwg_in_if ();
    logic                valid;
    logic                ready;
    logic                kind;
    mclwg_pkg::t_reg_a   seed_a;
    mclwg_pkg::t_reg_b   seed_b;
    mclwg_pkg::t_reg_c   seed_c;

    modport source (output valid, output kind, output seed_a, output seed_b,
                    output seed_c, input ready);
    modport sink   (input valid, input kind, input seed_a, input seed_b,
                    input seed_c, output ready);
endinterface

// Output channel: one keystream word per beat
interface mclwg_out_if ();
    logic                    valid;
    logic                    ready;
    mclwg_pkg::t_out_word    random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

### sv/majority_clocked_lfsr_word_gen_core.sv
// Channel  | Direction | Payload                          | Beat
// ---------+-----------+----------------------------------+--------------------------------
// i_gen    | in        | kind, seed_a, seed_b, seed_c     | load seeds or request one word
// o_word   | out       | random_word                      | one keystream word
//
// A load beat writes the seeds into the three registers when accepted. A generate beat
// is accepted in S_IDLE; S_RUN then does one majority-clocked tick of the three shift
// registers per cycle, each tick adding one keystream bit to a serial word register.
// i_rst_n is synchronous, active low, and clears all three registers to zero.
// The finished word waits in an output register; the next beat is accepted while it
// waits, and a run only stalls at its end if that register is still full.
`default_nettype none

module majority_clocked_lfsr_word_gen_core #(
    parameter int unsigned WORD_BITS = 23
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mclwg_in_if.sink    i_gen,
    mclwg_out_if.source o_word
);

`include "majority_clocked_lfsr_word_gen_core_assert.svh"

    localparam int unsigned CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_cnt                  r_cnt, n_cnt;
    mclwg_pkg::t_reg_a     r_a, n_a;
    mclwg_pkg::t_reg_b     r_b, n_b;
    mclwg_pkg::t_reg_c     r_c, n_c;
    t_word                 r_word, n_word;
    logic                  r_out_valid, n_out_valid;
    mclwg_pkg::t_out_word  r_out_data, n_out_data;

    logic ca, cb, cc, maj;
    logic en_a, en_b, en_c;
    logic fb_a, fb_b, fb_c;
    logic ks_bit;
    logic last_tick;
    logic out_free;
    t_word tick_word;

    // majority vote over the clock bits
    assign ca   = r_a[mclwg_pkg::A_CLK_BIT];
    assign cb   = r_b[mclwg_pkg::B_CLK_BIT];
    assign cc   = r_c[mclwg_pkg::C_CLK_BIT];
    assign maj  = (ca & cb) | (ca & cc) | (cb & cc);
    assign en_a = (ca == maj);
    assign en_b = (cb == maj);
    assign en_c = (cc == maj);

    // feedback of each register
    assign fb_a = r_a[mclwg_pkg::A_TAP0] ^ r_a[mclwg_pkg::A_TAP1]
                ^ r_a[mclwg_pkg::A_TAP2] ^ r_a[mclwg_pkg::A_TAP3];
    assign fb_b = r_b[mclwg_pkg::B_TAP0] ^ r_b[mclwg_pkg::B_TAP1];
    assign fb_c = r_c[mclwg_pkg::C_TAP0] ^ r_c[mclwg_pkg::C_TAP1]
                ^ r_c[mclwg_pkg::C_TAP2] ^ r_c[mclwg_pkg::C_TAP3];

    // keystream bit: top bits of the clocked registers only
    assign ks_bit = (en_a & r_a[mclwg_pkg::A_W-1])
                  ^ (en_b & r_b[mclwg_pkg::B_W-1])
                  ^ (en_c & r_c[mclwg_pkg::C_W-1]);

    // shift the new bit in at the top so that tick i ends at bit i
    assign tick_word = (r_word >> 1) | (t_word'(ks_bit) << (WORD_BITS - 1));

    assign last_tick = (r_cnt == t_cnt'(WORD_BITS - 1));
    assign out_free  = !r_out_valid || o_word.ready;

    // sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_word      = r_word;
        n_out_valid = r_out_valid && !o_word.ready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_gen.valid) begin
                    if (i_gen.kind == mclwg_pkg::KIND_LOAD) begin
                        n_a = i_gen.seed_a;
                        n_b = i_gen.seed_b;
                        n_c = i_gen.seed_c;
                    end else begin
                        n_state = S_RUN;
                        n_cnt   = '0;
                    end
                end
            end
            S_RUN: begin
                if (en_a) n_a = {r_a[mclwg_pkg::A_W-2:0], fb_a};
                if (en_b) n_b = {r_b[mclwg_pkg::B_W-2:0], fb_b};
                if (en_c) n_c = {r_c[mclwg_pkg::C_W-2:0], fb_c};
                n_word = tick_word;
                n_cnt  = r_cnt + t_cnt'(1);
                if (last_tick) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = mclwg_pkg::OUT_W'(tick_word);
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // hold the word until the output register drains
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mclwg_pkg::OUT_W'(r_word);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and shift registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_a         <= n_a;
            r_b         <= n_b;
            r_c         <= n_c;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_out_data <= n_out_data;
    end

    assign i_gen.ready        = (r_state == S_IDLE);
    assign o_word.valid       = r_out_valid;
    assign o_word.random_word = r_out_data;

    // checks
    `MCLWG_ASSERT_SAME(a_majority_clocks_two, r_state == S_RUN, $countones({en_a, en_b, en_c}) >= 2, "fewer than two registers clocked in a tick")
    `MCLWG_ASSERT_NEXT(a_gen_starts_run, i_gen.valid && i_gen.ready && (i_gen.kind == mclwg_pkg::KIND_GEN), (r_state == S_RUN) && (r_cnt == '0), "generate beat did not start a run")
    `MCLWG_ASSERT_NEXT(a_last_tick_delivers, (r_state == S_RUN) && last_tick && out_free, o_word.valid && (r_state == S_IDLE), "finished word not presented")
    `MCLWG_ASSERT_SAME(a_done_means_full, r_state == S_DONE, o_word.valid, "run held back with output register empty")

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned WORD_BITS   = 23;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_BEATS = 1000;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    // one queued input beat; a sync point holds the sender until all words are back
    typedef struct {
        logic              sync_point;
        mclwg_pkg::t_kind  kind;
        mclwg_pkg::t_reg_a seed_a;
        mclwg_pkg::t_reg_b seed_b;
        mclwg_pkg::t_reg_c seed_c;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    mclwg_in_if  gen_if ();
    mclwg_out_if word_if ();

    majority_clocked_lfsr_word_gen_core #(
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gen   (gen_if),
        .o_word  (word_if)
    );

    t_beat                beat_queue[$];
    mclwg_pkg::t_out_word word_expect[$];
    mclwg_pkg::t_reg_a    lfsr_a;
    mclwg_pkg::t_reg_b    lfsr_b;
    mclwg_pkg::t_reg_c    lfsr_c;
    logic                 beat_taken;
    int unsigned          err_cnt;
    int unsigned          cycle_cnt;
    int unsigned          run_cycles;
    int unsigned          hold_left;
    int unsigned          burst_left;
    int unsigned          gap_left;
    int unsigned          mode_left;
    t_rx_mode             rx_mode;
    t_beat                nxt;

    always #1 i_clk = ~i_clk;

    // count one line per mismatch
    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // run the three registers for one word, advancing the local copies
    function automatic mclwg_pkg::t_out_word keystream_word();
        mclwg_pkg::t_out_word w;
        logic                 ca;
        logic                 cb;
        logic                 cc;
        logic                 maj;
        logic                 ks;
        int unsigned          i;
        w = '0;
        for (i = 0; i < WORD_BITS; i++) begin
            ca  = lfsr_a[mclwg_pkg::A_CLK_BIT];
            cb  = lfsr_b[mclwg_pkg::B_CLK_BIT];
            cc  = lfsr_c[mclwg_pkg::C_CLK_BIT];
            maj = (ca & cb) | (ca & cc) | (cb & cc);
            ks  = 1'b0;
            if (ca == maj) begin
                ks ^= lfsr_a[mclwg_pkg::A_W-1];
                lfsr_a = {lfsr_a[mclwg_pkg::A_W-2:0],
                          lfsr_a[mclwg_pkg::A_TAP0] ^ lfsr_a[mclwg_pkg::A_TAP1]
                          ^ lfsr_a[mclwg_pkg::A_TAP2] ^ lfsr_a[mclwg_pkg::A_TAP3]};
            end
            if (cb == maj) begin
                ks ^= lfsr_b[mclwg_pkg::B_W-1];
                lfsr_b = {lfsr_b[mclwg_pkg::B_W-2:0],
                          lfsr_b[mclwg_pkg::B_TAP0] ^ lfsr_b[mclwg_pkg::B_TAP1]};
            end
            if (cc == maj) begin
                ks ^= lfsr_c[mclwg_pkg::C_W-1];
                lfsr_c = {lfsr_c[mclwg_pkg::C_W-2:0],
                          lfsr_c[mclwg_pkg::C_TAP0] ^ lfsr_c[mclwg_pkg::C_TAP1]
                          ^ lfsr_c[mclwg_pkg::C_TAP2] ^ lfsr_c[mclwg_pkg::C_TAP3]};
            end
            if (i < mclwg_pkg::OUT_W) w[i] = ks;
        end
        return w;
    endfunction

    function automatic void add_load(input mclwg_pkg::t_reg_a a, input mclwg_pkg::t_reg_b b,
                                     input mclwg_pkg::t_reg_c c);
        t_beat bt;
        bt.sync_point = 1'b0;
        bt.kind       = mclwg_pkg::KIND_LOAD;
        bt.seed_a     = a;
        bt.seed_b     = b;
        bt.seed_c     = c;
        beat_queue.push_back(bt);
    endfunction

    // seed fields carry noise, which the block must ignore
    function automatic void add_gen();
        t_beat bt;
        bt.sync_point = 1'b0;
        bt.kind       = mclwg_pkg::KIND_GEN;
        bt.seed_a     = mclwg_pkg::t_reg_a'($urandom());
        bt.seed_b     = mclwg_pkg::t_reg_b'($urandom());
        bt.seed_c     = mclwg_pkg::t_reg_c'($urandom());
        beat_queue.push_back(bt);
    endfunction

    function automatic void add_sync();
        t_beat bt;
        bt.sync_point = 1'b1;
        bt.kind       = mclwg_pkg::KIND_LOAD;
        bt.seed_a     = '0;
        bt.seed_b     = '0;
        bt.seed_c     = '0;
        beat_queue.push_back(bt);
    endfunction

    // cycle count for the run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // check returned words, then predict from accepted beats
    always @(posedge i_clk) begin
        beat_taken <= gen_if.valid && gen_if.ready;
        if (i_rst_n) begin
            if (word_if.valid && word_if.ready) begin
                if (word_expect.size() == 0) begin
                    report($sformatf("unexpected word %h", word_if.random_word));
                end else if (word_if.random_word !== word_expect[0]) begin
                    report($sformatf("random_word got %h want %h",
                                     word_if.random_word, word_expect[0]));
                    void'(word_expect.pop_front());
                end else begin
                    void'(word_expect.pop_front());
                end
            end
            if (gen_if.valid && gen_if.ready) begin
                if (gen_if.kind == mclwg_pkg::KIND_LOAD) begin
                    lfsr_a = gen_if.seed_a;
                    lfsr_b = gen_if.seed_b;
                    lfsr_c = gen_if.seed_c;
                end else begin
                    word_expect.push_back(keystream_word());
                end
            end
        end
    end

    // sender: bursts of beats with random gaps, held at sync points
    always @(negedge i_clk) begin
        if (i_rst_n && (!gen_if.valid || beat_taken)) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                gen_if.valid <= 1'b0;
            end else if (beat_queue.size() != 0 && beat_queue[0].sync_point) begin
                gen_if.valid <= 1'b0;
                if (word_expect.size() == 0) void'(beat_queue.pop_front());
            end else if (beat_queue.size() != 0) begin
                nxt = beat_queue.pop_front();
                gen_if.valid  <= 1'b1;
                gen_if.kind   <= nxt.kind;
                gen_if.seed_a <= nxt.seed_a;
                gen_if.seed_b <= nxt.seed_b;
                gen_if.seed_c <= nxt.seed_c;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                gen_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-offs so the block fills and stalls its input
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            run_cycles <= run_cycles + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (run_cycles == 2000 || run_cycles == 14000) begin
                hold_left <= 400;
            end
        end
    end

    // receiver: stall pattern that changes mode from time to time
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 200);
                case ($urandom_range(0, 2))
                    0:       rx_mode = RX_OPEN;
                    1:       rx_mode = RX_LIGHT;
                    default: rx_mode = RX_HEAVY;
                endcase
            end else begin
                mode_left = mode_left - 1;
            end
            if (hold_left != 0) begin
                word_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:  word_if.ready <= 1'b1;
                    RX_LIGHT: word_if.ready <= ($urandom_range(0, 3) != 0);
                    default:  word_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int unsigned i;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        gen_if.valid  = 1'b0;
        gen_if.kind   = mclwg_pkg::KIND_LOAD;
        gen_if.seed_a = '0;
        gen_if.seed_b = '0;
        gen_if.seed_c = '0;
        word_if.ready = 1'b0;
        beat_taken    = 1'b0;
        lfsr_a        = '0;
        lfsr_b        = '0;
        lfsr_c        = '0;
        err_cnt       = 0;
        cycle_cnt     = 0;
        run_cycles    = 0;
        hold_left     = 0;
        burst_left    = 0;
        gap_left      = 0;
        mode_left     = 0;
        rx_mode       = RX_OPEN;

        // directed: all-zero registers after reset give zero words
        add_gen();
        // all ones
        add_load(mclwg_pkg::t_reg_a'('1), mclwg_pkg::t_reg_b'('1), mclwg_pkg::t_reg_c'('1));
        add_gen();
        add_gen();
        // a zero register stays zero
        add_load('0, mclwg_pkg::t_reg_b'($urandom()), mclwg_pkg::t_reg_c'($urandom()));
        add_gen();
        add_load(mclwg_pkg::t_reg_a'($urandom()), '0, '0);
        add_gen();
        // all clock bits set: every register steps
        add_load(mclwg_pkg::t_reg_a'(1 << mclwg_pkg::A_CLK_BIT),
                 mclwg_pkg::t_reg_b'(1 << mclwg_pkg::B_CLK_BIT),
                 mclwg_pkg::t_reg_c'(1 << mclwg_pkg::C_CLK_BIT));
        add_gen();
        // first register out-voted
        add_load(mclwg_pkg::t_reg_a'((1 << mclwg_pkg::A_CLK_BIT) | (1 << (mclwg_pkg::A_W-1))),
                 mclwg_pkg::t_reg_b'(1 << (mclwg_pkg::B_W-1)),
                 mclwg_pkg::t_reg_c'(1 << (mclwg_pkg::C_W-1)));
        add_gen();
        // second register out-voted
        add_load(mclwg_pkg::t_reg_a'(1 << (mclwg_pkg::A_W-1)),
                 mclwg_pkg::t_reg_b'((1 << mclwg_pkg::B_CLK_BIT) | (1 << (mclwg_pkg::B_W-1))),
                 mclwg_pkg::t_reg_c'(1 << (mclwg_pkg::C_W-1)));
        add_gen();
        // extremes mixed
        add_load(mclwg_pkg::t_reg_a'('1), '0, mclwg_pkg::t_reg_c'('1));
        add_gen();
        // back-to-back loads: the second one wins
        add_load(mclwg_pkg::t_reg_a'($urandom()), mclwg_pkg::t_reg_b'($urandom()),
                 mclwg_pkg::t_reg_c'($urandom()));
        add_load(mclwg_pkg::t_reg_a'($urandom()), mclwg_pkg::t_reg_b'($urandom()),
                 mclwg_pkg::t_reg_c'($urandom()));
        add_gen();
        add_gen();
        add_sync();

        // random: mostly words, occasional reseeds
        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i == RANDOM_BEATS / 2) add_sync();
            if ($urandom_range(0, 9) == 0) begin
                add_load(($urandom_range(0, 7) == 0) ? mclwg_pkg::t_reg_a'(0)
                                                     : mclwg_pkg::t_reg_a'($urandom()),
                         ($urandom_range(0, 7) == 0) ? mclwg_pkg::t_reg_b'(0)
                                                     : mclwg_pkg::t_reg_b'($urandom()),
                         ($urandom_range(0, 7) == 0) ? mclwg_pkg::t_reg_c'(0)
                                                     : mclwg_pkg::t_reg_c'($urandom()));
            end else begin
                add_gen();
            end
        end

        // release reset on a falling clock edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all beats sent and every word back
        while ((beat_queue.size() != 0 || gen_if.valid || word_expect.size() != 0)
               && cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        repeat (WORD_BITS + 10) @(posedge i_clk);

        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
        end else if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
